// File: hw/rtl/bitmap_row_allocator_with_stats_unit_assert.svh
// Assertion macros for the bitmap row allocator.
// Used by modules that have clk and rst_n in scope; no other dependencies.
`ifndef BITMAP_ROW_ALLOCATOR_WITH_STATS_UNIT_ASSERT_SVH
`define BITMAP_ROW_ALLOCATOR_WITH_STATS_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BRASU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BRASU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/brasu_pkg.sv
// Package for the bitmap row allocator: constants, payload structs, state codes.
// Used by brasu_div and bitmap_row_allocator_with_stats_unit; depends on nothing.
package brasu_pkg;

    localparam int ROWS_DEFAULT = 64;
    localparam int ADDR_W       = 5;
    localparam int DATA_W       = 64;
    localparam int HANDLE_W     = 64;
    localparam int SIZE_W       = 16;
    localparam int STAT_W       = 3;
    localparam int ROW_OUT_W    = 6;
    localparam int CNT_OUT_W    = 7;
    localparam int TOTAL_W      = 32;
    localparam int DIV_STEP_W   = 6;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_ROW_SIZE = 2'd0;
    localparam reg_idx_t REG_CPU_BASE = 2'd1;
    localparam reg_idx_t REG_GPU_BASE = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef logic [STAT_W-1:0] status_t;
    localparam status_t STAT_OK        = 3'd0;
    localparam status_t STAT_NO_HEAP   = 3'd1;
    localparam status_t STAT_EXHAUSTED = 3'd2;
    localparam status_t STAT_FOREIGN   = 3'd3;
    localparam status_t STAT_MISMATCH  = 3'd4;
    localparam status_t STAT_BAD_FREE  = 3'd5;

    typedef struct packed {
        logic                opcode;
        logic [HANDLE_W-1:0] cpu_handle;
        logic [HANDLE_W-1:0] gpu_handle;
    } cmd_t;

    typedef struct packed {
        status_t              status;
        logic [ROW_OUT_W-1:0] row_index;
        logic [HANDLE_W-1:0]  out_cpu_handle;
        logic [HANDLE_W-1:0]  out_gpu_handle;
        logic [CNT_OUT_W-1:0] used_rows;
        logic [CNT_OUT_W-1:0] peak_rows;
        logic [TOTAL_W-1:0]   alloc_total;
        logic [TOTAL_W-1:0]   free_total;
    } rsp_t;

    typedef struct packed {
        logic                start;
        logic [HANDLE_W-1:0] dividend;
        logic [SIZE_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [HANDLE_W-1:0] quotient;
        logic [SIZE_W-1:0]   remainder;
    } div_rsp_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_A_MUL,
        S_A_CPU,
        S_A_GPU,
        S_F_CSUB,
        S_F_GSUB,
        S_F_DIV,
        S_F_RD,
        S_F_CHK
    } state_t;

endpackage

// File: hw/rtl/brasu_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module brasu_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/brasu_div.sv
// Restoring divider, one quotient bit per cycle: 64-bit dividend by 16-bit divisor.
// Depends on brasu_pkg.
module brasu_div (
    input  logic                clk,
    input  logic                rst_n,
    input  brasu_pkg::div_req_t req,
    output brasu_pkg::div_rsp_t rsp
);

    logic [brasu_pkg::HANDLE_W-1:0]   quo_reg;
    logic [brasu_pkg::SIZE_W-1:0]     rem_reg;
    logic [brasu_pkg::SIZE_W-1:0]     dvs_reg;
    logic [brasu_pkg::DIV_STEP_W-1:0] cnt_reg;
    logic                             run_reg;
    logic                             done_reg;
    logic [brasu_pkg::SIZE_W:0]       trial;
    logic [brasu_pkg::SIZE_W:0]       diff;
    logic                             fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[brasu_pkg::HANDLE_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[brasu_pkg::HANDLE_W-2:0], fits};
            rem_reg <= fits ? diff[brasu_pkg::SIZE_W-1:0] : trial[brasu_pkg::SIZE_W-1:0];
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// File: hw/rtl/bitmap_row_allocator_with_stats_unit.sv
// Top level of the bitmap row allocator: APB registers, sequencer, shared adder.
// Depends on brasu_pkg, brasu_ram, brasu_div and the assertion macro header.
//
// One request is taken when start is high and busy is low; its single result
// appears on rsp for exactly one cycle with done high and cannot be stalled.
// After reset the busy-bit RAM is swept clear, one row per cycle, while busy
// stays high. A request with row size zero is answered from idle with no-heap
// status. An allocate scans the busy bits one row at a time, a read state and
// a check state per row, through the RAM's registered read port, then forms
// both handles with one multiply and two passes through the shared 64-bit
// adder. A free subtracts the CPU and GPU bases in the shared adder, divides
// the offset by the row size in the bit-serial divider, then reads and clears
// the row; it ends early when a handle is foreign or the offsets differ.
`include "bitmap_row_allocator_with_stats_unit_assert.svh"

module bitmap_row_allocator_with_stats_unit #(
    parameter int ROWS = brasu_pkg::ROWS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  brasu_pkg::cmd_t              cmd,
    output logic                         done,
    output brasu_pkg::rsp_t              rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [brasu_pkg::ADDR_W-1:0] paddr,
    input  logic [brasu_pkg::DATA_W-1:0] pwdata,
    output logic [brasu_pkg::DATA_W-1:0] prdata,
    output logic                         pready
);

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW = $clog2(ROWS + 1);
    localparam int PW = RW + brasu_pkg::SIZE_W;
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    logic [brasu_pkg::SIZE_W-1:0]   row_size_reg;
    logic [brasu_pkg::HANDLE_W-1:0] cpu_base_reg;
    logic [brasu_pkg::HANDLE_W-1:0] gpu_base_reg;
    brasu_pkg::reg_idx_t            cfg_idx;
    logic                           cfg_wr;

    brasu_pkg::state_t              state_reg, state_next;
    logic [RW-1:0]                  scan_reg, scan_next;
    logic [PW-1:0]                  prod_reg, prod_next;
    logic [brasu_pkg::HANDLE_W-1:0] hold_reg, hold_next;
    logic                           foreign_reg, foreign_next;
    brasu_pkg::cmd_t                cmd_reg, cmd_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [CW-1:0]                  peak_reg, peak_next;
    logic [brasu_pkg::TOTAL_W-1:0]  alloc_reg, alloc_next;
    logic [brasu_pkg::TOTAL_W-1:0]  free_reg, free_next;
    brasu_pkg::rsp_t                rsp_reg, rsp_next;
    logic                           done_reg, done_next;

    logic                           ram_we;
    logic [RW-1:0]                  ram_waddr;
    logic [0:0]                     ram_wdata;
    logic [RW-1:0]                  ram_raddr;
    logic [0:0]                     ram_rdata;

    logic [brasu_pkg::HANDLE_W-1:0] add_a;
    logic [brasu_pkg::HANDLE_W-1:0] add_b;
    logic                           add_sub;
    logic [brasu_pkg::HANDLE_W:0]   add_res;

    brasu_pkg::div_req_t            div_req;
    brasu_pkg::div_rsp_t            div_rsp;

    logic                           emit;
    brasu_pkg::status_t             e_status;
    logic [RW-1:0]                  e_row;
    logic [brasu_pkg::HANDLE_W-1:0] e_cpu;
    logic [brasu_pkg::HANDLE_W-1:0] e_gpu;

    brasu_ram #(
        .WIDTH (1),
        .DEPTH (ROWS)
    ) u_busy_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    brasu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Configuration port
    assign cfg_idx = paddr[brasu_pkg::ADDR_W-1:3];
    assign cfg_wr  = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_size_reg <= '0;
            cpu_base_reg <= '0;
            gpu_base_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                brasu_pkg::REG_ROW_SIZE: row_size_reg <= pwdata[brasu_pkg::SIZE_W-1:0];
                brasu_pkg::REG_CPU_BASE: cpu_base_reg <= pwdata;
                brasu_pkg::REG_GPU_BASE: gpu_base_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            brasu_pkg::REG_ROW_SIZE: prdata = brasu_pkg::DATA_W'(row_size_reg);
            brasu_pkg::REG_CPU_BASE: prdata = cpu_base_reg;
            brasu_pkg::REG_GPU_BASE: prdata = gpu_base_reg;
            default:                 prdata = '0;
        endcase
    end

    // Shared 64-bit adder
    always_comb
    begin
        if (add_sub)
        begin
            add_res = {1'b0, add_a} - {1'b0, add_b};
        end
        else
        begin
            add_res = {1'b0, add_a} + {1'b0, add_b};
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brasu_pkg::S_CLEAR;
            scan_reg  <= '0;
            count_reg <= '0;
            peak_reg  <= '0;
            alloc_reg <= '0;
            free_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            count_reg <= count_next;
            peak_reg  <= peak_next;
            alloc_reg <= alloc_next;
            free_reg  <= free_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        hold_reg    <= hold_next;
        foreign_reg <= foreign_next;
        cmd_reg     <= cmd_next;
        rsp_reg     <= rsp_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        scan_next        = scan_reg;
        prod_next        = prod_reg;
        hold_next        = hold_reg;
        foreign_next     = foreign_reg;
        cmd_next         = cmd_reg;
        count_next       = count_reg;
        peak_next        = peak_reg;
        alloc_next       = alloc_reg;
        free_next        = free_reg;
        ram_we           = 1'b0;
        ram_waddr        = scan_reg;
        ram_wdata        = 1'b0;
        ram_raddr        = scan_reg;
        add_a            = '0;
        add_b            = '0;
        add_sub          = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = hold_reg;
        div_req.divisor  = row_size_reg;
        emit             = 1'b0;
        e_status         = brasu_pkg::STAT_OK;
        e_row            = '0;
        e_cpu            = '0;
        e_gpu            = '0;

        unique case (state_reg)
            brasu_pkg::S_CLEAR:
            begin
                ram_we = 1'b1;
                if (scan_reg == LAST_ROW)
                begin
                    scan_next  = '0;
                    state_next = brasu_pkg::S_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            brasu_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    if (row_size_reg == '0)
                    begin
                        emit     = 1'b1;
                        e_status = brasu_pkg::STAT_NO_HEAP;
                    end
                    else
                    begin
                        case (cmd.opcode)
                            brasu_pkg::OP_ALLOC:
                            begin
                                scan_next  = '0;
                                state_next = brasu_pkg::S_A_RD;
                            end
                            brasu_pkg::OP_FREE: state_next = brasu_pkg::S_F_CSUB;
                            default: ;
                        endcase
                    end
                end
            end
            brasu_pkg::S_A_RD: state_next = brasu_pkg::S_A_CHK;
            brasu_pkg::S_A_CHK:
            begin
                if (!ram_rdata[0])
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = 1'b1;
                    count_next = count_reg + 1'b1;
                    alloc_next = alloc_reg + 1'b1;
                    if (count_next > peak_reg)
                    begin
                        peak_next = count_next;
                    end
                    state_next = brasu_pkg::S_A_MUL;
                end
                else if (scan_reg == LAST_ROW)
                begin
                    emit     = 1'b1;
                    e_status = brasu_pkg::STAT_EXHAUSTED;
                end
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = brasu_pkg::S_A_RD;
                end
            end
            brasu_pkg::S_A_MUL:
            begin
                prod_next  = PW'(scan_reg) * PW'(row_size_reg);
                state_next = brasu_pkg::S_A_CPU;
            end
            brasu_pkg::S_A_CPU:
            begin
                add_a      = cpu_base_reg;
                add_b      = brasu_pkg::HANDLE_W'(prod_reg);
                hold_next  = add_res[brasu_pkg::HANDLE_W-1:0];
                state_next = brasu_pkg::S_A_GPU;
            end
            brasu_pkg::S_A_GPU:
            begin
                add_a    = gpu_base_reg;
                add_b    = brasu_pkg::HANDLE_W'(prod_reg);
                emit     = 1'b1;
                e_row    = scan_reg;
                e_cpu    = hold_reg;
                e_gpu    = add_res[brasu_pkg::HANDLE_W-1:0];
            end
            brasu_pkg::S_F_CSUB:
            begin
                add_a        = cmd_reg.cpu_handle;
                add_b        = cpu_base_reg;
                add_sub      = 1'b1;
                hold_next    = add_res[brasu_pkg::HANDLE_W-1:0];
                foreign_next = add_res[brasu_pkg::HANDLE_W];
                state_next   = brasu_pkg::S_F_GSUB;
            end
            brasu_pkg::S_F_GSUB:
            begin
                add_a   = cmd_reg.gpu_handle;
                add_b   = gpu_base_reg;
                add_sub = 1'b1;
                if (foreign_reg || add_res[brasu_pkg::HANDLE_W])
                begin
                    emit     = 1'b1;
                    e_status = brasu_pkg::STAT_FOREIGN;
                end
                else if (add_res[brasu_pkg::HANDLE_W-1:0] != hold_reg)
                begin
                    emit     = 1'b1;
                    e_status = brasu_pkg::STAT_MISMATCH;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = brasu_pkg::S_F_DIV;
                end
            end
            brasu_pkg::S_F_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.remainder != '0)
                    begin
                        emit     = 1'b1;
                        e_status = brasu_pkg::STAT_MISMATCH;
                    end
                    else if (div_rsp.quotient >= brasu_pkg::HANDLE_W'(ROWS))
                    begin
                        emit     = 1'b1;
                        e_status = brasu_pkg::STAT_BAD_FREE;
                    end
                    else
                    begin
                        scan_next  = div_rsp.quotient[RW-1:0];
                        state_next = brasu_pkg::S_F_RD;
                    end
                end
            end
            brasu_pkg::S_F_RD: state_next = brasu_pkg::S_F_CHK;
            brasu_pkg::S_F_CHK:
            begin
                if (!ram_rdata[0] || count_reg == '0)
                begin
                    emit     = 1'b1;
                    e_status = brasu_pkg::STAT_BAD_FREE;
                end
                else
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg - 1'b1;
                    free_next  = free_reg + 1'b1;
                    emit       = 1'b1;
                    e_row      = scan_reg;
                end
            end
            default: state_next = brasu_pkg::S_IDLE;
        endcase

        if (emit)
        begin
            state_next = brasu_pkg::S_IDLE;
        end

        done_next = emit;
        rsp_next  = rsp_reg;
        if (emit)
        begin
            rsp_next.status         = e_status;
            rsp_next.row_index      = brasu_pkg::ROW_OUT_W'(e_row);
            rsp_next.out_cpu_handle = e_cpu;
            rsp_next.out_gpu_handle = e_gpu;
            rsp_next.used_rows      = brasu_pkg::CNT_OUT_W'(count_next);
            rsp_next.peak_rows      = brasu_pkg::CNT_OUT_W'(peak_next);
            rsp_next.alloc_total    = alloc_next;
            rsp_next.free_total     = free_next;
        end
    end

    assign busy = (state_reg != brasu_pkg::S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    `BRASU_ASSERT_NOW(a_done_idle, done, !busy, "result shown while sequencer busy")
    `BRASU_ASSERT_NEXT(a_accept_moves, start && !busy, busy || done, "accepted request lost")
    `BRASU_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CW'(ROWS), "used count above row total")
    `BRASU_ASSERT_NOW(a_peak_ge_used, 1'b1, peak_reg >= count_reg, "peak below used count")
    `BRASU_ASSERT_NOW(a_div_in_wait, div_rsp.done, state_reg == brasu_pkg::S_F_DIV,
        "divider finished outside free wait")

endmodule
